@@ src/kpd_pkg.sv @@
// kpd_pkg: shared types and constants of the keypad scanner with debounce and key queue
// no dependencies; imported by every module of the block

package kpd_pkg;

   localparam int MATRIX_BITS = 16;
   localparam int KEY_IDX_W   = $clog2(MATRIX_BITS);
   localparam int MAX_KEYS    = 16;
   localparam int TICK_W      = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEYMAP_LO = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEYMAP_HI = 3'd4;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [3:0]  ROWS_RESET     = 4'd4;
   localparam logic [3:0]  COLUMNS_RESET  = 4'd4;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_FLUSH = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_PRESS   = 2'd0,
      PH_CONFIRM = 2'd1,
      PH_RELEASE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_ONE  = 2'd1,
      CLS_MANY = 2'd2
   } scan_class_type;

   typedef struct packed {
      scan_class_type cls;
      logic [7:0]     ch;
   } scan_code_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_PUSH  = 2'd1,
      CMD_POP   = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_op_type;

   // one classified item on its way from the front part to the key buffer
   typedef struct packed {
      cmd_op_type op;
      logic [7:0] ch;
      phase_type  phase;
   } cmd_type;

endpackage

@@ src/keypad_scan_debounce_fifo_top.sv @@
// keypad_scan_debounce_fifo_top: matrix keypad scanner with debounce and a key ring buffer
// depends on kpd_pkg, kpd_front, kpd_cmd_queue and kpd_back
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_type, req_pressed_matrix
//   rsp      out        rsp_valid / rsp_stall     popped, front, count, debounce state
//   csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// one item per cycle sustained while rsp_stall stays low; the front part classifies an item
// in the cycle it is accepted; a result passes the queue, then the ring read stage, then the
// output register on its way to rsp; the ring has a single, registered read port
// reset is synchronous and active high; configuration and pointers return to defaults, the
// ring contents stay undefined and are never shown before they are written
// req_stall rises only when the two-entry command queue is full, which takes a held rsp_stall
// csr_ready is always high; a write to an index past the last register is dropped

module keypad_scan_debounce_fifo_top #(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [kpd_pkg::MATRIX_BITS-1:0]  req_pressed_matrix,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_popped_valid,
   output logic [7:0]                       rsp_popped_char,
   output logic                             rsp_front_valid,
   output logic [7:0]                       rsp_front_char,
   output logic [3:0]                       rsp_buffered_count,
   output logic [1:0]                       rsp_debounce_state,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kpd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import kpd_pkg::*;

   logic    req_accept;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;
   cmd_type front_cmd;
   cmd_type q_head;

   // every transfer on req becomes exactly one queue entry
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;
   assign csr_ready  = 1'b1;

   // front part: config registers, tick counter, classification, debounce
   kpd_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_accept         (req_accept),
      .req_type           (req_type),
      .req_pressed_matrix (req_pressed_matrix),
      .cmd_out            (front_cmd)
   );

   // decouples the classifier from a stalled result channel
   kpd_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_cmd),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (q_head)
   );

   // back part: ring buffer, pointers and result register
   kpd_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (q_not_empty),
      .cmd                (q_head),
      .cmd_pop            (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_popped_valid   (rsp_popped_valid),
      .rsp_popped_char    (rsp_popped_char),
      .rsp_front_valid    (rsp_front_valid),
      .rsp_front_char     (rsp_front_char),
      .rsp_buffered_count (rsp_buffered_count),
      .rsp_debounce_state (rsp_debounce_state)
   );

endmodule

@@ src/kpd_front.sv @@
// kpd_front: configuration registers, tick counter, matrix classification and debounce machine
// depends on kpd_pkg; turns each accepted item into one command for the key buffer

module kpd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [kpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kpd_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_accept,
   input  logic [1:0]                       req_type,
   input  logic [kpd_pkg::MATRIX_BITS-1:0]  req_pressed_matrix,
   output kpd_pkg::cmd_type                 cmd_out
);
   import kpd_pkg::*;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   logic [15:0]              debounce_ff;
   logic [3:0]               rows_ff;
   logic [3:0]               cols_ff;
   logic [CSR_DATA_W-1:0]    keymap_lo_ff;
   logic [CSR_DATA_W-1:0]    keymap_hi_ff;
   logic [TICK_W-1:0]        tick_ff;
   logic [TICK_W-1:0]        tick_in;
   logic [TICK_W-1:0]        tick_inc;
   phase_type                phase_ff;
   phase_type                phase_in;
   scan_code_type            prev_ff;

   logic [7:0]               key_area;
   logic [MATRIX_BITS-1:0]   key_mask;
   logic [MATRIX_BITS-1:0]   hits;
   logic                     multi_hit;
   logic [KEY_IDX_W-1:0]     hit_idx;
   logic [2*CSR_DATA_W-1:0]  keymap_all;
   logic [7:0]               hit_char;
   scan_code_type            scan_code;
   logic                     is_tick;
   logic                     scan_due;
   logic                     push_key;

   // a bit is a key when it lies inside rows x columns
   assign key_area = 8'(rows_ff) * 8'(cols_ff);

   always_comb begin
      for (int i = 0; i < MATRIX_BITS; i++) begin
         key_mask[i] = (8'(i) < key_area) && (i < MAX_KEYS);
      end
   end

   assign hits      = req_pressed_matrix & key_mask;
   assign multi_hit = (hits & (hits - MATRIX_BITS'(1))) != '0;

   // only a lone key needs its index, so scan order does not matter
   always_comb begin
      hit_idx = '0;
      for (int i = MATRIX_BITS - 1; i >= 0; i--) begin
         if (hits[i]) begin
            hit_idx = KEY_IDX_W'(i);
         end
      end
   end

   assign keymap_all = {keymap_hi_ff, keymap_lo_ff};
   assign hit_char   = keymap_all[{hit_idx, 3'b000} +: 8];

   always_comb begin
      if (hits == '0) begin
         scan_code = '{cls: CLS_NONE, ch: 8'd0};
      end else if (multi_hit) begin
         scan_code = '{cls: CLS_MANY, ch: 8'd0};
      end else begin
         scan_code = '{cls: CLS_ONE, ch: hit_char};
      end
   end

   // saturating tick counter, scan once it passes the setting
   assign is_tick  = req_accept && (req_type == REQ_TICK);
   assign tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 1'b1;
   assign scan_due = is_tick && (tick_inc > {1'b0, debounce_ff});

   always_comb begin
      tick_in = tick_ff;
      if (scan_due) begin
         tick_in = '0;
      end else if (is_tick) begin
         tick_in = tick_inc;
      end
   end

   // debounce machine: next state
   always_comb begin
      phase_in = phase_ff;
      if (scan_due) begin
         case (phase_ff)
            PH_PRESS: begin
               if (scan_code.cls == CLS_ONE) begin
                  phase_in = PH_CONFIRM;
               end else if (scan_code.cls == CLS_MANY) begin
                  phase_in = PH_RELEASE;
               end
            end
            PH_CONFIRM: begin
               if (scan_code == prev_ff && scan_code.cls == CLS_ONE) begin
                  phase_in = PH_RELEASE;
               end else if (scan_code.cls == CLS_MANY) begin
                  phase_in = PH_RELEASE;
               end else if (scan_code.cls == CLS_NONE) begin
                  phase_in = PH_PRESS;
               end
            end
            PH_RELEASE: begin
               if (scan_code.cls == CLS_NONE) begin
                  phase_in = PH_PRESS;
               end
            end
            default: begin
               phase_in = PH_PRESS;
            end
         endcase
      end
   end

   // debounce machine: outputs
   always_comb begin
      case (phase_ff)
         PH_CONFIRM: begin
            push_key = scan_due && (scan_code == prev_ff) && (scan_code.cls == CLS_ONE);
         end
         default: begin
            push_key = 1'b0;
         end
      endcase
   end

   always_comb begin
      cmd_out.ch    = scan_code.ch;
      cmd_out.phase = phase_in;
      case (req_type)
         REQ_TICK:  cmd_out.op = push_key ? CMD_PUSH : CMD_NONE;
         REQ_POP:   cmd_out.op = CMD_POP;
         REQ_FLUSH: cmd_out.op = CMD_FLUSH;
         default:   cmd_out.op = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLUMNS_RESET;
         keymap_lo_ff <= '0;
         keymap_hi_ff <= '0;
         tick_ff      <= '0;
         phase_ff     <= PH_PRESS;
         prev_ff      <= '{cls: CLS_NONE, ch: 8'd0};
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_DEBOUNCE:  debounce_ff  <= csr_data[15:0];
               CSR_ROWS:      rows_ff      <= csr_data[3:0];
               CSR_COLUMNS:   cols_ff      <= csr_data[3:0];
               CSR_KEYMAP_LO: keymap_lo_ff <= csr_data;
               CSR_KEYMAP_HI: keymap_hi_ff <= csr_data;
               default: ;
            endcase
         end
         tick_ff  <= tick_in;
         phase_ff <= phase_in;
         if (scan_due) begin
            prev_ff <= scan_code;
         end
      end
   end

   a_scan_clears_counter: assert property (@(posedge clock) disable iff (reset)
      scan_due |=> tick_ff == '0)
      else $error("tick counter not cleared after a scan");

   a_push_then_release: assert property (@(posedge clock) disable iff (reset)
      push_key |=> phase_ff == PH_RELEASE)
      else $error("confirmed key did not move the machine to waiting release");

   a_phase_only_on_scan: assert property (@(posedge clock) disable iff (reset)
      !scan_due |=> $stable(phase_ff))
      else $error("debounce phase moved without a scan");

endmodule

@@ src/kpd_cmd_queue.sv @@
// kpd_cmd_queue: two-entry command queue between the classifier and the key buffer
// depends on kpd_pkg for the command struct

module kpd_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kpd_pkg::cmd_type  push_data,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output kpd_pkg::cmd_type  head
);
   import kpd_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_sel_ff;
   logic       rd_sel_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;

   assign not_empty = fill_ff != 2'd0;
   assign full      = fill_ff == 2'd2;
   assign head      = slot_ff[rd_sel_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_sel_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_sel_ff <= ~wr_sel_ff;
         end
         if (pop) begin
            rd_sel_ff <= ~rd_sel_ff;
         end
         fill_ff <= fill_in;
      end
   end

endmodule

@@ src/kpd_back.sv @@
// kpd_back: key ring buffer, pointer update and result register
// depends on kpd_pkg; consumes commands from kpd_cmd_queue

module kpd_back #(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  kpd_pkg::cmd_type    cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_popped_valid,
   output logic [7:0]          rsp_popped_char,
   output logic                rsp_front_valid,
   output logic [7:0]          rsp_front_char,
   output logic [3:0]          rsp_buffered_count,
   output logic [1:0]          rsp_debounce_state
);
   import kpd_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == AW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [7:0]    ring_mem [BUFFER_DEPTH];
   logic [7:0]    mem_q_ff;
   logic          byp_ff;
   logic [7:0]    byp_data_ff;
   logic [AW-1:0] wr_ff;
   logic [AW-1:0] rd_ff;
   logic [AW-1:0] wr_in;
   logic [AW-1:0] rd_in;
   logic [AW-1:0] fill_in;
   logic          write_en;
   logic          pop_hit;
   logic [7:0]    front_now;
   logic          adv;
   logic          take;

   logic          p1_valid_ff;
   logic          p1_pv_ff;
   logic [7:0]    p1_pc_ff;
   logic          p1_fv_ff;
   logic [AW-1:0] p1_cnt_ff;
   phase_type     p1_phase_ff;

   logic          rsp_valid_ff;
   logic          rsp_pv_ff;
   logic [7:0]    rsp_pc_ff;
   logic          rsp_fv_ff;
   logic [7:0]    rsp_fc_ff;
   logic [AW-1:0] rsp_cnt_ff;
   phase_type     rsp_phase_ff;

   // whole back part moves together unless the result is held
   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign take    = adv && cmd_valid;
   assign cmd_pop = take;

   // registered read of the oldest entry, with the same-cycle write forwarded
   assign front_now = byp_ff ? byp_data_ff : mem_q_ff;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      write_en = 1'b0;
      pop_hit  = 1'b0;
      if (take) begin
         case (cmd.op)
            CMD_PUSH: begin
               write_en = 1'b1;
               wr_in    = ptr_next(wr_ff);
            end
            CMD_POP: begin
               if (wr_ff != rd_ff) begin
                  pop_hit = 1'b1;
                  rd_in   = ptr_next(rd_ff);
               end
            end
            CMD_FLUSH: begin
               rd_in = wr_ff;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      fill_in = wr_in - rd_in;
      if (wr_in < rd_in) begin
         fill_in = fill_in + AW'(BUFFER_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (write_en) begin
            ring_mem[wr_ff] <= cmd.ch;
         end
         mem_q_ff <= ring_mem[rd_in];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         byp_data_ff <= cmd.ch;
         p1_pv_ff    <= pop_hit;
         p1_pc_ff    <= pop_hit ? front_now : 8'd0;
         p1_fv_ff    <= wr_in != rd_in;
         p1_cnt_ff   <= fill_in;
         p1_phase_ff <= cmd.phase;
         rsp_pv_ff    <= p1_pv_ff;
         rsp_pc_ff    <= p1_pc_ff;
         rsp_fv_ff    <= p1_fv_ff;
         rsp_fc_ff    <= p1_fv_ff ? front_now : 8'd0;
         rsp_cnt_ff   <= p1_cnt_ff;
         rsp_phase_ff <= p1_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         byp_ff       <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         byp_ff       <= write_en && (rd_in == wr_ff);
         p1_valid_ff  <= take;
         rsp_valid_ff <= p1_valid_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_popped_valid   = rsp_pv_ff;
   assign rsp_popped_char    = rsp_pc_ff;
   assign rsp_front_valid    = rsp_fv_ff;
   assign rsp_front_char     = rsp_fc_ff;
   assign rsp_buffered_count = 4'(rsp_cnt_ff);
   assign rsp_debounce_state = rsp_phase_ff;

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (take && cmd.op == CMD_FLUSH) |=> wr_ff == rd_ff)
      else $error("flush left keys in the ring");

   a_pop_moves_read: assert property (@(posedge clock) disable iff (reset)
      (take && cmd.op == CMD_POP && wr_ff != rd_ff) |=> rd_ff != $past(rd_ff))
      else $error("pop on a nonempty ring kept the read pointer");

   a_stage_to_result: assert property (@(posedge clock) disable iff (reset)
      (adv && p1_valid_ff) |=> rsp_valid_ff)
      else $error("staged result lost on its way to the output register");

endmodule

@@ test/tb_top.sv @@
// tb_top: self-checking bench for the keypad scanner with debounce and key ring buffer
// drives ticks, pops and flushes, predicts every status result and compares field by field
// depends on kpd_pkg and keypad_scan_debounce_fifo_top

module tb_top;
   import kpd_pkg::*;

   // request code with no meaning; the block only reports status
   localparam logic [1:0] REQ_UNDEFINED = 2'd3;
   // register index past the last register; the write is dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [TICK_W-1:0] TICK_CEILING = {TICK_W{1'b1}};

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // one status result as the rsp channel shows it
   typedef struct packed {
      logic       popped_valid;
      logic [7:0] popped_char;
      logic       front_valid;
      logic [7:0] front_char;
      logic [3:0] count;
      logic [1:0] phase;
   } key_status_type;

   // directed stimulus row; pinned rows carry a hand-written status
   typedef struct {
      logic [1:0]     kind;
      logic [15:0]    matrix;
      bit             pinned;
      key_status_type status;
   } dir_row_type;

   typedef struct {
      logic [15:0]   debounce;
      logic [3:0]    rows;
      logic [3:0]    cols;
      idle_mode_type mode;
      int            items;
      int            pop_pct;
      bit            same_chars;
   } traffic_phase_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_type = REQ_TICK;
   logic [MATRIX_BITS-1:0] req_pressed_matrix = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_popped_valid;
   logic [7:0]             rsp_popped_char;
   logic                   rsp_front_valid;
   logic [7:0]             rsp_front_char;
   logic [3:0]             rsp_buffered_count;
   logic [1:0]             rsp_debounce_state;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEBOUNCE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // hand-written status travels with the item, so it is sampled at the same edge
   logic           pin_use = 1'b0;
   key_status_type pin_status = '0;

   keypad_scan_debounce_fifo_top dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // predictor state: configuration copy, debounce machine, tick counter, key ring
   // ---------------------------------------------------------------------------
   logic [15:0]       cfg_debounce = DEBOUNCE_RESET;
   logic [3:0]        cfg_rows     = ROWS_RESET;
   logic [3:0]        cfg_cols     = COLUMNS_RESET;
   logic [63:0]       cfg_keymap_lo = '0;
   logic [63:0]       cfg_keymap_hi = '0;
   phase_type         model_phase  = PH_PRESS;
   scan_code_type     prev_scan    = '{CLS_NONE, 8'h00};
   logic [TICK_W-1:0] tick_count   = '0;
   logic [7:0]        key_ring_model [16];
   logic [3:0]        wr_ptr = '0;
   logic [3:0]        rd_ptr = '0;

   key_status_type pending_status [$];   // statuses still owed by the block
   int          errors = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   logic [15:0] key_mask = 16'hFFFF;   // matrix bits the current geometry actually scans

   // advance the keypad by one request and return the status it must report
   task automatic advance_keypad_model(input logic [1:0] kind, input logic [15:0] matrix,
                                       output key_status_type status);
      int            hits, idx, c, r;
      scan_code_type code;
      status = '0;
      case (kind)
         REQ_TICK: begin
            if (tick_count != TICK_CEILING) tick_count++;
            if (tick_count > {1'b0, cfg_debounce}) begin
               tick_count = '0;
               hits = 0;
               code = '{CLS_NONE, 8'h00};
               // columns outer, rows inner; the first hit picks the character
               for (c = 0; c < cfg_cols; c++) begin
                  for (r = 0; r < cfg_rows; r++) begin
                     idx = r * cfg_cols + c;
                     if (idx < MATRIX_BITS && idx < MAX_KEYS && matrix[idx]) begin
                        hits++;
                        if (hits == 1)
                           code.ch = (idx < 8) ? cfg_keymap_lo[8*idx +: 8]
                                               : cfg_keymap_hi[8*(idx-8) +: 8];
                     end
                  end
               end
               if (hits == 0) begin
                  code = '{CLS_NONE, 8'h00};
               end else if (hits == 1) begin
                  code.cls = CLS_ONE;
               end else begin
                  code = '{CLS_MANY, 8'h00};
               end
               case (model_phase)
                  PH_PRESS: begin
                     if (code.cls == CLS_ONE) model_phase = PH_CONFIRM;
                     else if (code.cls == CLS_MANY) model_phase = PH_RELEASE;
                  end
                  PH_CONFIRM: begin
                     // same single key, or any key with the same character, on two scans
                     if (code == prev_scan && code.cls == CLS_ONE) begin
                        key_ring_model[wr_ptr] = code.ch;
                        wr_ptr++;
                        model_phase = PH_RELEASE;
                     end else if (code.cls == CLS_MANY) begin
                        model_phase = PH_RELEASE;
                     end else if (code.cls == CLS_NONE) begin
                        model_phase = PH_PRESS;
                     end
                  end
                  PH_RELEASE: begin
                     if (code.cls == CLS_NONE) model_phase = PH_PRESS;
                  end
                  default: ;
               endcase
               prev_scan = code;
            end
         end
         REQ_POP: begin
            if (wr_ptr != rd_ptr) begin
               status.popped_valid = 1'b1;
               status.popped_char  = key_ring_model[rd_ptr];
               rd_ptr++;
            end
         end
         REQ_FLUSH: rd_ptr = wr_ptr;
         default: ;
      endcase
      // no full check: a push that catches up with the read side looks empty
      if (wr_ptr != rd_ptr) begin
         status.front_valid = 1'b1;
         status.front_char  = key_ring_model[rd_ptr];
      end
      status.count = wr_ptr - rd_ptr;
      status.phase = model_phase;
   endtask

   function automatic void report_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // scoreboard: predict on every req transfer, compare on every rsp transfer
   // prediction runs first so a result in the same cycle as its request would still find its entry
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      key_status_type want, got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            advance_keypad_model(req_type, req_pressed_matrix, want);
            if (pin_use) want = pin_status;
            pending_status.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_popped_valid, rsp_popped_char, rsp_front_valid, rsp_front_char,
                    rsp_buffered_count, rsp_debounce_state};
            if (pending_status.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got %0h", $time, got);
            end else begin
               want = pending_status.pop_front();
               report_field("popped_valid", want.popped_valid, got.popped_valid);
               report_field("popped_char", want.popped_char, got.popped_char);
               report_field("front_valid", want.front_valid, got.front_valid);
               report_field("front_char", want.front_char, got.front_char);
               report_field("buffered_count", want.count, got.count);
               report_field("debounce_state", want.phase, got.phase);
            end
         end
      end
   end

   // receiver back-pressure, one coin per cycle
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // ---------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------
   function automatic void set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin idle_pct = 49; stall_pct = 0;  end
         IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 49; end
         default:       begin idle_pct = 38; stall_pct = 38; end
      endcase
   endfunction

   // one req transfer; valid stays high afterwards unless the caller lowers it
   task automatic send_item(input logic [1:0] kind, input logic [15:0] matrix,
                            input bit pinned, input key_status_type status);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_pressed_matrix <= matrix;
      pin_use            <= pinned;
      pin_status         <= status;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for every owed result, then a short settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_DEBOUNCE:  cfg_debounce  = data[15:0];
         CSR_ROWS:      cfg_rows      = data[3:0];
         CSR_COLUMNS:   cfg_cols      = data[3:0];
         CSR_KEYMAP_LO: cfg_keymap_lo = data;
         CSR_KEYMAP_HI: cfg_keymap_hi = data;
         default: ;
      endcase
   endtask

   // reprogram the block while it is idle and recompute the scanned key area
   task automatic configure(input logic [15:0] debounce, input logic [3:0] rows,
                            input logic [3:0] cols, input logic [63:0] map_lo,
                            input logic [63:0] map_hi);
      int c, r;
      drain();
      write_csr(CSR_DEBOUNCE, {48'h0, debounce});
      write_csr(CSR_ROWS, {60'h0, rows});
      write_csr(CSR_COLUMNS, {60'h0, cols});
      write_csr(CSR_KEYMAP_LO, map_lo);
      write_csr(CSR_KEYMAP_HI, map_hi);
      write_csr(CSR_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;
      key_mask = '0;
      for (c = 0; c < cols; c++)
         for (r = 0; r < rows; r++)
            if (r * cols + c < MATRIX_BITS) key_mask[r * cols + c] = 1'b1;
   endtask

   function automatic logic [15:0] one_key();
      int          idx;
      logic [15:0] single = 16'h0001;
      do idx = $urandom_range(15); while (!key_mask[idx]);
      return single << idx;
   endfunction

   // one tick, sometimes preceded by a pop, a flush or a meaningless request
   task automatic random_tick(input logic [15:0] matrix, input int pop_pct, inout int sent);
      int pick;
      pick = $urandom_range(99);
      if (pick < pop_pct) begin
         send_item(REQ_POP, 16'($urandom), 1'b0, '0);
         sent++;
      end else if (pop_pct != 0 && pick < pop_pct + 2) begin
         send_item(REQ_FLUSH, 16'($urandom), 1'b0, '0);
         sent++;
      end else if (pick < pop_pct + 3) begin
         send_item(REQ_UNDEFINED, 16'($urandom), 1'b0, '0);
      end
      send_item(REQ_TICK, matrix, 1'b0, '0);
      sent++;
   endtask

   // mostly keystrokes, single keys or chords, held across one or more scans and released, the rest raw noise
   task automatic random_traffic(input int target, input int pop_pct);
      int          sent, pick, span, hold;
      logic [15:0] held;
      sent = 0;
      span = cfg_debounce + 1;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (key_mask != 0 && pick < 75) begin
            held = one_key();
            if (pick >= 60) held |= one_key();   // chord, usually two keys
            if ($urandom_range(3) == 0) held |= 16'($urandom) & ~key_mask;
            hold = span * $urandom_range(1, 3) + $urandom_range(0, span);
            repeat (hold) random_tick(held, pop_pct, sent);
            // release, possibly with bits that lie outside the scanned area
            held = $urandom_range(1) ? (16'($urandom) & ~key_mask) : 16'h0000;
            hold = span * $urandom_range(1, 2);
            repeat (hold) random_tick(held, pop_pct, sent);
         end else begin
            pick = $urandom_range(3);
            send_item(2'(pick), 16'($urandom), 1'b0, '0);
            if (2'(pick) != REQ_UNDEFINED) sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // stimulus tables
   // ---------------------------------------------------------------------------
   // reset configuration: debounce 10, so no tick here reaches a scan
   dir_row_type boot_rows [4] = '{
      '{REQ_POP,       16'h0000, 1'b1, '0},   // pop on an empty ring
      '{REQ_FLUSH,     16'hFFFF, 1'b1, '0},
      '{REQ_UNDEFINED, 16'hFFFF, 1'b1, '0},
      '{REQ_TICK,      16'hFFFF, 1'b1, '0}    // counter only, no scan
   };

   // debounce 0 on a 4x4 pad; key 0 maps to 00, key 15 to ff, key 4 to 34, key 5 to 35
   dir_row_type key_rows [25] = '{
      '{REQ_TICK, 16'h0001, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 4'd0, PH_CONFIRM}},
      '{REQ_TICK, 16'h0001, 1'b1, '{1'b0, 8'h00, 1'b1, 8'h00, 4'd1, PH_RELEASE}},
      '{REQ_TICK, 16'h0000, 1'b1, '{1'b0, 8'h00, 1'b1, 8'h00, 4'd1, PH_PRESS}},
      '{REQ_TICK, 16'h8000, 1'b0, '0},   // highest key, character ff
      '{REQ_TICK, 16'h8000, 1'b0, '0},
      '{REQ_TICK, 16'h0000, 1'b0, '0},
      '{REQ_TICK, 16'h0003, 1'b0, '0},   // two keys while waiting for a press
      '{REQ_TICK, 16'h0000, 1'b0, '0},
      '{REQ_TICK, 16'h0010, 1'b0, '0},
      '{REQ_TICK, 16'h0020, 1'b0, '0},   // other key before confirm, stays waiting
      '{REQ_TICK, 16'h0020, 1'b0, '0},
      '{REQ_TICK, 16'h0000, 1'b0, '0},
      '{REQ_TICK, 16'h0010, 1'b0, '0},
      '{REQ_TICK, 16'h0000, 1'b0, '0},   // bounce: released before confirm
      '{REQ_TICK, 16'h0010, 1'b0, '0},
      '{REQ_TICK, 16'h0030, 1'b0, '0},   // second key joins before confirm
      '{REQ_TICK, 16'h0000, 1'b0, '0},
      '{REQ_POP,  16'hFFFF, 1'b1, '{1'b1, 8'h00, 1'b1, 8'hFF, 4'd2, PH_PRESS}},
      '{REQ_POP,  16'h0000, 1'b0, '0},
      '{REQ_POP,  16'h5A5A, 1'b0, '0},
      '{REQ_POP,  16'hFFFF, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 4'd0, PH_PRESS}},
      '{REQ_TICK, 16'h0002, 1'b0, '0},
      '{REQ_TICK, 16'h0002, 1'b0, '0},
      '{REQ_FLUSH, 16'hFFFF, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 4'd0, PH_RELEASE}},
      '{REQ_UNDEFINED, 16'hFFFF, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 4'd0, PH_RELEASE}}
   };

   // geometries from the empty pad to oversized counts; pop 0 lets the ring wrap
   traffic_phase_type traffic_plan [10] = '{
      '{16'd0, 4'd4,  4'd4,  IDLE_NONE,     220, 25, 1'b0},
      '{16'd1, 4'd2,  4'd8,  IDLE_SENDER,   220, 25, 1'b0},
      '{16'd0, 4'd8,  4'd2,  IDLE_RECEIVER, 250, 0,  1'b0},
      '{16'd2, 4'd3,  4'd5,  IDLE_BOTH,     200, 30, 1'b1},
      '{16'd0, 4'd8,  4'd8,  IDLE_NONE,     200, 20, 1'b0},
      '{16'd0, 4'd0,  4'd4,  IDLE_SENDER,   80,  20, 1'b0},
      '{16'd0, 4'd15, 4'd15, IDLE_RECEIVER, 150, 20, 1'b0},
      '{16'd3, 4'd1,  4'd1,  IDLE_BOTH,     150, 25, 1'b1},
      '{16'd0, 4'd5,  4'd0,  IDLE_BOTH,     80,  20, 1'b0},
      '{16'd0, 4'd4,  4'd4,  IDLE_BOTH,     200, 45, 1'b0}
   };

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [7:0] fill;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      foreach (boot_rows[i])
         send_item(boot_rows[i].kind, boot_rows[i].matrix, boot_rows[i].pinned,
                   boot_rows[i].status);
      configure(16'd0, 4'd4, 4'd4, 64'h3736_3534_3332_3100, 64'hFF80_4645_4443_4241);
      foreach (key_rows[i])
         send_item(key_rows[i].kind, key_rows[i].matrix, key_rows[i].pinned,
                   key_rows[i].status);

      foreach (traffic_plan[p]) begin
         set_idling(IDLE_NONE);
         if (traffic_plan[p].same_chars) begin
            // every key shares one character, so different keys still confirm
            fill = 8'($urandom);
            configure(traffic_plan[p].debounce, traffic_plan[p].rows, traffic_plan[p].cols,
                      {8{fill}}, {8{fill}});
         end else begin
            configure(traffic_plan[p].debounce, traffic_plan[p].rows, traffic_plan[p].cols,
                      {$urandom, $urandom}, {$urandom, $urandom});
         end
         set_idling(traffic_plan[p].mode);
         random_traffic(traffic_plan[p].items, traffic_plan[p].pop_pct);
      end

      // longest debounce: a held key stays short of a scan, only the counter moves
      set_idling(IDLE_NONE);
      configure(16'hFFFF, 4'd8, 4'd2, {$urandom, $urandom}, {$urandom, $urandom});
      repeat (40) send_item(REQ_TICK, 16'h0400, 1'b0, '0);
      repeat (3) send_item(REQ_POP, 16'($urandom), 1'b0, '0);
      drain();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
src/kpd_pkg.sv
src/kpd_front.sv
src/kpd_cmd_queue.sv
src/kpd_back.sv
src/keypad_scan_debounce_fifo_top.sv
test/tb_top.sv
